/* design/gbr_pkg.sv */
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the grid reachability search
// Payload structs, register indexes, command codes and controller states.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int GRID_SIDE_DEF = 32;
  localparam int ADDR_W_DEF    = 10;
  localparam int COORD_W       = 5;
  localparam int COUNT_W       = 11;
  localparam int CFG_IDX_W     = 2;

  // map word: one visited bit and one obstacle bit per cell
  localparam int MAP_W   = 2;
  localparam int MAP_VIS = 0;
  localparam int MAP_OBS = 1;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ROW = 2'd0,
    CFG_START_COL = 2'd1,
    CFG_GOAL_ROW  = 2'd2,
    CFG_GOAL_COL  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_POP,
    S_CHECK,
    S_EXPAND,
    S_CLEAN
  } state_e;

  typedef enum logic [2:0] {
    DIR_ROW_INC,
    DIR_ROW_DEC,
    DIR_COL_INC,
    DIR_COL_DEC,
    DIR_END
  } dir_e;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               blocked;
  } in_item_t;

  typedef struct packed {
    logic               reached;
    logic [COUNT_W-1:0] visited_count;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] goal_row;
    logic [COORD_W-1:0] goal_col;
  } cfg_t;

endpackage

/* design/grid_bfs_reachability_top.sv */
// ----------------------------------------------------------------------------
// grid_bfs_reachability_top: breadth-first reachability search on a grid
// Input items either write one obstacle flag (cmd 0) or run a search (cmd 1)
// from the configured start cell to the configured goal cell over four
// neighbours. A search returns one result: reached flag and visited count.
// Configuration (start/goal row and column) uses a separate write channel,
// always ready, and must be written only while the block is idle; the block
// itself does not enforce this. Obstacle loads are taken one per cycle while
// idle with no result waiting and give no result. A search is accepted, then
// each dequeued cell takes a queue read, a goal check, four neighbour map
// reads overlapped with their checks and one trailing check; the goal cell
// stops after its check, and the search ends when the queue runs empty; the
// single-port-per-direction map and queue memories set this pace. After the
// result is registered, a sweep clears the visited marks from the queue
// contents. Input is not ready from a search transfer until that sweep is
// done, and not ready while a result waits for out_ready_i; the output
// register holds the result until it is taken.
// After reset the map memory is cleared, all 2**(2*clog2(GRID_SIDE)) cells
// (1024 at the default size), with in_ready_o low.
// ----------------------------------------------------------------------------
module grid_bfs_reachability_top #(
  parameter int GRID_SIDE = gbr_pkg::GRID_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gbr_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gbr_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gbr_pkg::COORD_W-1:0]   cfg_data_i
);

  localparam int AW = 2 * $clog2(GRID_SIDE);

  gbr_pkg::cfg_t             cfg;
  logic                      map_re;
  logic [AW-1:0]             map_raddr;
  logic [gbr_pkg::MAP_W-1:0] map_rdata;
  logic [gbr_pkg::MAP_W-1:0] map_we;
  logic [AW-1:0]             map_waddr;
  logic [gbr_pkg::MAP_W-1:0] map_wdata;
  logic                      q_re;
  logic [AW-1:0]             q_raddr;
  logic [AW-1:0]             q_rdata;
  logic                      q_we;
  logic [AW-1:0]             q_waddr;
  logic [AW-1:0]             q_wdata;

  gbr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gbr_map_mem #(
    .AddrW (AW)
  ) u_map_mem (
    .clk_i   (clk_i),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata)
  );

  gbr_queue_mem #(
    .AddrW (AW)
  ) u_queue_mem (
    .clk_i   (clk_i),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata)
  );

  gbr_ctrl #(
    .GRID_SIDE (GRID_SIDE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_i       (cfg),
    .map_re_o    (map_re),
    .map_raddr_o (map_raddr),
    .map_rdata_i (map_rdata),
    .map_we_o    (map_we),
    .map_waddr_o (map_waddr),
    .map_wdata_o (map_wdata),
    .q_re_o      (q_re),
    .q_raddr_o   (q_raddr),
    .q_rdata_i   (q_rdata),
    .q_we_o      (q_we),
    .q_waddr_o   (q_waddr),
    .q_wdata_o   (q_wdata)
  );

endmodule

/* design/gbr_cfg.sv */
// ----------------------------------------------------------------------------
// gbr_cfg: configuration registers
// Holds start and goal coordinates, written through the configuration channel.
// ----------------------------------------------------------------------------
module gbr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbr_pkg::COORD_W-1:0]    cfg_data_i,
  output gbr_pkg::cfg_t                  cfg_o
);

  gbr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (gbr_pkg::cfg_idx_e'(cfg_index_i))
        gbr_pkg::CFG_START_ROW: cfg_d.start_row = cfg_data_i;
        gbr_pkg::CFG_START_COL: cfg_d.start_col = cfg_data_i;
        gbr_pkg::CFG_GOAL_ROW:  cfg_d.goal_row  = cfg_data_i;
        gbr_pkg::CFG_GOAL_COL:  cfg_d.goal_col  = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/gbr_map_mem.sv */
// ----------------------------------------------------------------------------
// gbr_map_mem: cell map memory
// Two bits per cell (visited, obstacle), per-bit write enables, one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module gbr_map_mem #(
  parameter int AddrW = gbr_pkg::ADDR_W_DEF
) (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [gbr_pkg::MAP_W-1:0]  rdata_o,
  input  logic [gbr_pkg::MAP_W-1:0]  we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [gbr_pkg::MAP_W-1:0]  wdata_i
);

  localparam int Depth = 1 << AddrW;

  logic [gbr_pkg::MAP_W-1:0] mem_q [Depth];
  logic [gbr_pkg::MAP_W-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < gbr_pkg::MAP_W; b++) begin
      if (we_i[b]) begin
        mem_q[waddr_i][b] <= wdata_i[b];
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

/* design/gbr_queue_mem.sv */
// ----------------------------------------------------------------------------
// gbr_queue_mem: cell queue memory
// Holds the cell addresses of the search in visiting order.
// ----------------------------------------------------------------------------
module gbr_queue_mem #(
  parameter int AddrW = gbr_pkg::ADDR_W_DEF
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [AddrW-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [AddrW-1:0] wdata_i
);

  localparam int Depth = 1 << AddrW;

  logic [AddrW-1:0] mem_q [Depth];
  logic [AddrW-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

/* design/gbr_ctrl.sv */
// ----------------------------------------------------------------------------
// gbr_ctrl: search sequencer
// Loads obstacles, runs the breadth-first search over the map and queue
// memories, holds the result and unmarks visited cells after each search.
// ----------------------------------------------------------------------------
module gbr_ctrl #(
  parameter int GRID_SIDE = gbr_pkg::GRID_SIDE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  gbr_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output gbr_pkg::out_item_t                 out_data_o,
  input  gbr_pkg::cfg_t                      cfg_i,
  output logic                               map_re_o,
  output logic [2*$clog2(GRID_SIDE)-1:0]     map_raddr_o,
  input  logic [gbr_pkg::MAP_W-1:0]          map_rdata_i,
  output logic [gbr_pkg::MAP_W-1:0]          map_we_o,
  output logic [2*$clog2(GRID_SIDE)-1:0]     map_waddr_o,
  output logic [gbr_pkg::MAP_W-1:0]          map_wdata_o,
  output logic                               q_re_o,
  output logic [2*$clog2(GRID_SIDE)-1:0]     q_raddr_o,
  input  logic [2*$clog2(GRID_SIDE)-1:0]     q_rdata_i,
  output logic                               q_we_o,
  output logic [2*$clog2(GRID_SIDE)-1:0]     q_waddr_o,
  output logic [2*$clog2(GRID_SIDE)-1:0]     q_wdata_o
);

  localparam int RW    = $clog2(GRID_SIDE);
  localparam int AW    = 2 * RW;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int TW    = $clog2(CELLS + 1);
  localparam int SW    = AW + 1;
  localparam int CMPW  = ((gbr_pkg::COORD_W > RW) ? gbr_pkg::COORD_W : RW) + 1;

  gbr_pkg::state_e    state_q, state_d;
  gbr_pkg::dir_e      dir_q, dir_d;
  logic [TW-1:0]      head_q, head_d;
  logic [TW-1:0]      tail_q, tail_d;
  logic [SW-1:0]      sweep_q, sweep_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      pend_addr_q, pend_addr_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  gbr_pkg::out_item_t out_data_q, out_data_d;

  logic [RW-1:0] cur_row, cur_col;
  logic [RW:0]   row_inc, col_inc;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic          start_ok, load_ok, goal_hit;
  logic [AW-1:0] start_addr, load_addr;
  logic          in_fire, is_search, queue_empty, tail_full, sweep_more;

  assign cur_row = cur_q[AW-1:RW];
  assign cur_col = cur_q[RW-1:0];
  assign row_inc = {1'b0, cur_row} + (RW+1)'(1);
  assign col_inc = {1'b0, cur_col} + (RW+1)'(1);

  always_comb begin
    case (dir_q)
      gbr_pkg::DIR_ROW_INC: begin
        nb_ok   = row_inc < (RW+1)'(GRID_SIDE);
        nb_addr = {row_inc[RW-1:0], cur_col};
      end
      gbr_pkg::DIR_ROW_DEC: begin
        nb_ok   = cur_row != '0;
        nb_addr = {cur_row - RW'(1), cur_col};
      end
      gbr_pkg::DIR_COL_INC: begin
        nb_ok   = col_inc < (RW+1)'(GRID_SIDE);
        nb_addr = {cur_row, col_inc[RW-1:0]};
      end
      gbr_pkg::DIR_COL_DEC: begin
        nb_ok   = cur_col != '0;
        nb_addr = {cur_row, cur_col - RW'(1)};
      end
      default: begin
        nb_ok   = 1'b0;
        nb_addr = cur_q;
      end
    endcase
  end

  assign start_ok   = (CMPW'(cfg_i.start_row) < CMPW'(GRID_SIDE)) &&
                      (CMPW'(cfg_i.start_col) < CMPW'(GRID_SIDE));
  assign start_addr = {RW'(cfg_i.start_row), RW'(cfg_i.start_col)};
  assign load_ok    = (CMPW'(in_data_i.cell_row) < CMPW'(GRID_SIDE)) &&
                      (CMPW'(in_data_i.cell_col) < CMPW'(GRID_SIDE));
  assign load_addr  = {RW'(in_data_i.cell_row), RW'(in_data_i.cell_col)};
  assign goal_hit   = (CMPW'(q_rdata_i[AW-1:RW]) == CMPW'(cfg_i.goal_row)) &&
                      (CMPW'(q_rdata_i[RW-1:0]) == CMPW'(cfg_i.goal_col));

  assign in_ready_o  = (state_q == gbr_pkg::S_IDLE) && !out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_search   = in_data_i.cmd == gbr_pkg::CMD_SEARCH;
  assign queue_empty = head_q == tail_q;
  assign tail_full   = tail_q == TW'(CELLS);
  assign sweep_more  = sweep_q < SW'(tail_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbr_pkg::S_INIT: begin
        if (&sweep_q[AW-1:0]) state_d = gbr_pkg::S_IDLE;
      end
      gbr_pkg::S_IDLE: begin
        if (in_fire && is_search) begin
          state_d = start_ok ? gbr_pkg::S_POP : gbr_pkg::S_CLEAN;
        end
      end
      gbr_pkg::S_POP: begin
        state_d = queue_empty ? gbr_pkg::S_CLEAN : gbr_pkg::S_CHECK;
      end
      gbr_pkg::S_CHECK: begin
        state_d = goal_hit ? gbr_pkg::S_CLEAN : gbr_pkg::S_EXPAND;
      end
      gbr_pkg::S_EXPAND: begin
        if (dir_q == gbr_pkg::DIR_END) state_d = gbr_pkg::S_POP;
      end
      gbr_pkg::S_CLEAN: begin
        if (!sweep_more && !pend_q) state_d = gbr_pkg::S_IDLE;
      end
      default: state_d = gbr_pkg::S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    dir_d       = dir_q;
    head_d      = head_q;
    tail_d      = tail_q;
    sweep_d     = sweep_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    map_re_o    = 1'b0;
    map_raddr_o = nb_addr;
    map_we_o    = '0;
    map_waddr_o = '0;
    map_wdata_o = '0;
    q_re_o      = 1'b0;
    q_raddr_o   = '0;
    q_we_o      = 1'b0;
    q_waddr_o   = '0;
    q_wdata_o   = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      gbr_pkg::S_INIT: begin
        // power-up clear of obstacle and visited bits
        map_we_o    = '1;
        map_waddr_o = AW'(sweep_q);
        sweep_d     = (&sweep_q[AW-1:0]) ? '0 : sweep_q + SW'(1);
      end
      gbr_pkg::S_IDLE: begin
        if (in_fire && !is_search) begin
          if (load_ok) begin
            map_we_o[gbr_pkg::MAP_OBS]    = 1'b1;
            map_waddr_o                   = load_addr;
            map_wdata_o[gbr_pkg::MAP_OBS] = in_data_i.blocked;
          end
        end else if (in_fire) begin
          head_d  = '0;
          tail_d  = '0;
          sweep_d = '0;
          pend_d  = 1'b0;
          if (start_ok) begin
            map_we_o[gbr_pkg::MAP_VIS]    = 1'b1;
            map_waddr_o                   = start_addr;
            map_wdata_o[gbr_pkg::MAP_VIS] = 1'b1;
            q_we_o                        = 1'b1;
            q_waddr_o                     = '0;
            q_wdata_o                     = start_addr;
            tail_d                        = TW'(1);
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
          end
        end
      end
      gbr_pkg::S_POP: begin
        if (queue_empty) begin
          out_valid_d              = 1'b1;
          out_data_d.reached       = 1'b0;
          out_data_d.visited_count = gbr_pkg::COUNT_W'(tail_q);
        end else begin
          q_re_o    = 1'b1;
          q_raddr_o = AW'(head_q);
          head_d    = head_q + TW'(1);
        end
      end
      gbr_pkg::S_CHECK: begin
        cur_d  = q_rdata_i;
        dir_d  = gbr_pkg::DIR_ROW_INC;
        pend_d = 1'b0;
        if (goal_hit) begin
          out_valid_d              = 1'b1;
          out_data_d.reached       = 1'b1;
          out_data_d.visited_count = gbr_pkg::COUNT_W'(tail_q);
        end
      end
      gbr_pkg::S_EXPAND: begin
        // read of neighbour d overlaps the check of neighbour d-1
        if (dir_q != gbr_pkg::DIR_END) begin
          map_re_o    = nb_ok;
          pend_d      = nb_ok;
          pend_addr_d = nb_addr;
          dir_d       = gbr_pkg::dir_e'(dir_q + 3'd1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && !map_rdata_i[gbr_pkg::MAP_VIS] && !map_rdata_i[gbr_pkg::MAP_OBS]) begin
          map_we_o[gbr_pkg::MAP_VIS]    = 1'b1;
          map_waddr_o                   = pend_addr_q;
          map_wdata_o[gbr_pkg::MAP_VIS] = 1'b1;
          if (!tail_full) begin
            q_we_o    = 1'b1;
            q_waddr_o = AW'(tail_q);
            q_wdata_o = pend_addr_q;
            tail_d    = tail_q + TW'(1);
          end
        end
      end
      gbr_pkg::S_CLEAN: begin
        // every visited cell sits in the queue, so unmark them from there
        if (sweep_more) begin
          q_re_o    = 1'b1;
          q_raddr_o = AW'(sweep_q);
          sweep_d   = sweep_q + SW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) sweep_d = '0;
        end
        if (pend_q) begin
          map_we_o[gbr_pkg::MAP_VIS]    = 1'b1;
          map_waddr_o                   = q_rdata_i;
          map_wdata_o[gbr_pkg::MAP_VIS] = 1'b0;
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbr_pkg::S_INIT;
      dir_q       <= gbr_pkg::DIR_ROW_INC;
      head_q      <= '0;
      tail_q      <= '0;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      sweep_q     <= sweep_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    cur_q       <= cur_d;
    out_data_q  <= out_data_d;
  end

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= TW'(CELLS))
    else $error("queue tail beyond grid size");

  a_map_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_re_o && map_we_o != '0) |-> map_raddr_o != map_waddr_o)
    else $error("map read and write hit the same cell");

  a_result_then_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> state_q == gbr_pkg::S_CLEAN)
    else $error("result raised outside the unmark sweep");

  a_queue_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_we_o |-> (state_q == gbr_pkg::S_IDLE || state_q == gbr_pkg::S_EXPAND))
    else $error("queue written outside search");

endmodule
